/* hdl/int_field_formatter_core_defines.svh */
// assertion macros shared by the formatter rtl
// relies on clk and rst_n being visible where a macro is used
`ifndef INT_FIELD_FORMATTER_CORE_DEFINES_SVH
`define INT_FIELD_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication
`define IFMT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("formatter check failed");

// next-cycle implication
`define IFMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("formatter check failed");

`endif

/* hdl/ifmt_pkg.sv */
// shared constants, types and helpers of the integer field formatter
// no dependencies
`timescale 1ns / 1ps

package ifmt_pkg;

  localparam int FIELD_MAX_DEF  = 63;
  localparam int VALUE_BITS_DEF = 32;

  // digit count field covers the widest legal value
  localparam int NDIG_W = 5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic              neg;
    logic [NDIG_W-1:0] nd;
  } dig_stat_t;

  // upper bound on decimal digits for a value width
  function automatic int dig_max(input int vb);
    return (vb * 3 + 9) / 10 + 1;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    unique case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'ha: c = 8'h61;
      4'hb: c = 8'h62;
      4'hc: c = 8'h63;
      4'hd: c = 8'h64;
      4'he: c = 8'h65;
      4'hf: c = 8'h66;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

endpackage

/* hdl/ifmt_conv.sv */
// shift-and-add-3 step of the digit unit: adds 3 to every bcd digit of five or more
// depends on ifmt_pkg
`timescale 1ns / 1ps

module ifmt_conv #(
  parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
  localparam int DIG_MAX   = ifmt_pkg::dig_max(VALUE_BITS),
  localparam int DIG_BITS  = 4 * DIG_MAX
) (
  input  logic [DIG_BITS-1:0] dig,
  output logic [DIG_BITS-1:0] adj
);

  always_comb begin
    for (int k = 0; k < DIG_MAX; k++) begin
      adj[4*k +: 4] = (dig[4*k +: 4] >= 4'd5) ? (dig[4*k +: 4] + 4'd3)
                                               : dig[4*k +: 4];
    end
  end

endmodule

/* hdl/ifmt_emit.sv */
// character sequencer: field sizing and one output beat per character
// depends on ifmt_pkg
`timescale 1ns / 1ps

module ifmt_emit #(
  parameter int FIELD_MAX  = ifmt_pkg::FIELD_MAX_DEF,
  parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
  localparam int DIG_MAX   = ifmt_pkg::dig_max(VALUE_BITS),
  localparam int DIG_BITS  = 4 * DIG_MAX
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  ifmt_pkg::dig_stat_t   stat,
  input  logic [DIG_BITS-1:0]   digits,
  input  logic [5:0]            width,
  input  logic [5:0]            precision,
  output logic                  fin,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_ch,
  output logic                  out_last
);

  localparam int LEN_MAX = ((FIELD_MAX > DIG_MAX) ? FIELD_MAX : DIG_MAX) + 1;
  localparam int LEN_W   = $clog2(LEN_MAX + 1);
  localparam int CMP_W   = (LEN_W > 6) ? LEN_W : 6;
  localparam int DIG_W   = (DIG_MAX > 1) ? $clog2(DIG_MAX) : 1;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_MAX  = 3'd1;
  localparam logic [2:0] E_BODY = 3'd2;
  localparam logic [2:0] E_LEN  = 3'd3;
  localparam logic [2:0] E_POS  = 3'd4;
  localparam logic [2:0] E_RUN  = 3'd5;

  localparam logic [CMP_W-1:0] FMAX_C = CMP_W'(FIELD_MAX);

  logic [2:0]       state_r, state_nxt;
  logic [LEN_W-1:0] wc_r, wc_nxt, pc_r, pc_nxt, nd_r, nd_nxt;
  logic             neg_r, neg_nxt;
  logic [LEN_W-1:0] mx_r, mx_nxt, body_r, body_nxt, zc_r, zc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, sp_r, sp_nxt, zp_r, zp_nxt, dp_r, dp_nxt;
  logic [LEN_W-1:0] p_r, p_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_ch_r, out_ch_nxt;
  logic             out_last_r, out_last_nxt;
  logic             fin_r, fin_nxt;

  logic [3:0]       dig_a [DIG_MAX];
  logic [CMP_W-1:0] w_ext, p_ext;
  logic [LEN_W-1:0] len_m1, idx_full;
  logic [DIG_W-1:0] idx;
  logic             load;
  logic [7:0]       ch_c;

  for (genvar g = 0; g < DIG_MAX; g++) begin : g_dig
    assign dig_a[g] = digits[4*g +: 4];
  end

  assign w_ext    = CMP_W'(width);
  assign p_ext    = CMP_W'(precision);
  assign len_m1   = len_r - LEN_W'(1);
  assign idx_full = len_m1 - p_r;
  assign idx      = idx_full[DIG_W-1:0];
  assign load     = (state_r == E_RUN) && (!out_valid_r || out_ready);

  always_comb begin
    priority if (p_r < sp_r) begin
      ch_c = ifmt_pkg::CH_SPACE;
    end else if (p_r < zp_r) begin
      ch_c = ifmt_pkg::CH_MINUS;
    end else if (p_r < dp_r) begin
      ch_c = ifmt_pkg::CH_ZERO;
    end else begin
      ch_c = ifmt_pkg::digit_char(dig_a[idx]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wc_nxt        = wc_r;
    pc_nxt        = pc_r;
    nd_nxt        = nd_r;
    neg_nxt       = neg_r;
    mx_nxt        = mx_r;
    body_nxt      = body_r;
    zc_nxt        = zc_r;
    len_nxt       = len_r;
    sp_nxt        = sp_r;
    zp_nxt        = zp_r;
    dp_nxt        = dp_r;
    p_nxt         = p_r;
    out_ch_nxt    = out_ch_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    fin_nxt       = 1'b0;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          wc_nxt    = LEN_W'((w_ext > FMAX_C) ? FMAX_C : w_ext);
          pc_nxt    = LEN_W'((p_ext > FMAX_C) ? FMAX_C : p_ext);
          nd_nxt    = LEN_W'(stat.nd);
          neg_nxt   = stat.neg;
          state_nxt = E_MAX;
        end
      end
      E_MAX: begin
        mx_nxt    = (pc_r > nd_r) ? pc_r : nd_r;
        state_nxt = E_BODY;
      end
      E_BODY: begin
        body_nxt  = mx_r + LEN_W'(neg_r);
        zc_nxt    = mx_r - nd_r;
        state_nxt = E_LEN;
      end
      E_LEN: begin
        len_nxt   = (wc_r > body_r) ? wc_r : body_r;
        sp_nxt    = (wc_r > body_r) ? (wc_r - body_r) : '0;
        state_nxt = E_POS;
      end
      E_POS: begin
        zp_nxt    = sp_r + LEN_W'(neg_r);
        dp_nxt    = sp_r + LEN_W'(neg_r) + zc_r;
        p_nxt     = '0;
        state_nxt = E_RUN;
      end
      E_RUN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_c;
          out_last_nxt  = (p_r == len_m1);
          p_nxt         = p_r + LEN_W'(1);
          if (p_r == len_m1) begin
            fin_nxt   = 1'b1;
            state_nxt = E_IDLE;
          end
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fin_r       <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wc_r       <= wc_nxt;
    pc_r       <= pc_nxt;
    nd_r       <= nd_nxt;
    neg_r      <= neg_nxt;
    mx_r       <= mx_nxt;
    body_r     <= body_nxt;
    zc_r       <= zc_nxt;
    len_r      <= len_nxt;
    sp_r       <= sp_nxt;
    zp_r       <= zp_nxt;
    dp_r       <= dp_nxt;
    p_r        <= p_nxt;
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign fin       = fin_r;
  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_last  = out_last_r;

endmodule

/* hdl/ifmt_conv_unit.sv */
// digit unit: sign split, shift-and-add-3 binary to bcd or direct hex nibbles
// depends on ifmt_pkg and ifmt_conv
`timescale 1ns / 1ps

module ifmt_conv_unit #(
  parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
  localparam int DIG_MAX   = ifmt_pkg::dig_max(VALUE_BITS),
  localparam int DIG_BITS  = 4 * DIG_MAX
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         use_hex,
  output logic                         done,
  output ifmt_pkg::dig_stat_t          stat,
  output logic [DIG_BITS-1:0]          digits
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_CONV = 2'd1;
  localparam logic [1:0] C_FIND = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [VALUE_BITS-1:0]        mag_r, mag_nxt;
  logic [DIG_BITS-1:0]          dig_r, dig_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         neg_r, neg_nxt;
  logic [ifmt_pkg::NDIG_W-1:0]  nd_r, nd_nxt;
  logic                         done_r, done_nxt;

  logic [VALUE_BITS-1:0]        mag_in;
  logic [DIG_BITS-1:0]          adj;
  logic [ifmt_pkg::NDIG_W-1:0]  nd_c;

  assign mag_in = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

  // add 3 to every bcd digit of five or more before the shift
  ifmt_conv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_adj (
    .dig (dig_r),
    .adj (adj)
  );

  // leading nonzero digit, at least one digit
  always_comb begin
    nd_c = ifmt_pkg::NDIG_W'(1);
    for (int k = 0; k < DIG_MAX; k++) begin
      if (dig_r[4*k +: 4] != 4'd0) nd_c = ifmt_pkg::NDIG_W'(k + 1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    nd_nxt    = nd_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          neg_nxt = value[VALUE_BITS-1];
          mag_nxt = mag_in;
          cnt_nxt = '0;
          if (use_hex) begin
            dig_nxt   = DIG_BITS'(mag_in);
            state_nxt = C_FIND;
          end else begin
            dig_nxt   = '0;
            state_nxt = C_CONV;
          end
        end
      end
      C_CONV: begin
        dig_nxt = {adj[DIG_BITS-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) state_nxt = C_FIND;
      end
      C_FIND: begin
        nd_nxt    = nd_c;
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    dig_r <= dig_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    nd_r  <= nd_nxt;
  end

  assign done     = done_r;
  assign stat.neg = neg_r;
  assign stat.nd  = nd_r;
  assign digits   = dig_r;

endmodule

/* hdl/int_field_formatter_core.sv */
// Integer field formatter, printf style %d and %x with width and precision.
//
// Input channel (in_valid/in_ready): one beat carries a signed value, a
// decimal/hex select, a field width and a precision (0 means none). Width
// and precision above FIELD_MAX are clamped to FIELD_MAX.
// Output channel (out_valid/out_ready): one beat per ASCII character,
// leftmost first, out_last high on the final character of the field.
// Per item: shift-and-add-3 steps in the digit unit for decimal (none
// for hex), the digit count, the hand-over, field sizing (E_MAX, E_BODY,
// E_LEN, E_POS), then one character per cycle while out_ready is high.
// in_ready is low during reset and from acceptance until the cycle after the last character
// is in the output register; the next item may be taken while it waits.
// A stalled receiver holds the output register and the character
// sequencer. Reset (rst_n, synchronous) empties the output register and
// returns both sequencers to idle.
// depends on ifmt_pkg, ifmt_conv_unit, ifmt_emit and the defines header
`timescale 1ns / 1ps
`include "int_field_formatter_core_defines.svh"

module int_field_formatter_core #(
  parameter int FIELD_MAX  = ifmt_pkg::FIELD_MAX_DEF,
  parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_use_hex,
  input  logic [5:0]                   in_width,
  input  logic [5:0]                   in_precision,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_ch,
  output logic                         out_last
);

  localparam int DIG_BITS = 4 * ifmt_pkg::dig_max(VALUE_BITS);

  logic                busy_r, busy_nxt;
  logic [5:0]          width_r, prec_r;
  logic                accept;
  logic                conv_done;
  logic                emit_fin;
  ifmt_pkg::dig_stat_t stat;
  logic [DIG_BITS-1:0] digits;

  assign accept   = in_valid && in_ready;
  assign in_ready = rst_n && !busy_r;

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (emit_fin) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      width_r <= in_width;
      prec_r  <= in_precision;
    end
  end

  ifmt_conv_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .value   (in_value),
    .use_hex (in_use_hex),
    .done    (conv_done),
    .stat    (stat),
    .digits  (digits)
  );

  ifmt_emit #(
    .FIELD_MAX (FIELD_MAX),
    .VALUE_BITS(VALUE_BITS)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (conv_done),
    .stat      (stat),
    .digits    (digits),
    .width     (width_r),
    .precision (prec_r),
    .fin       (emit_fin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ch    (out_ch),
    .out_last  (out_last)
  );

  `IFMT_ASSERT_NEXT(a_accept_busy, accept, !in_ready)
  `IFMT_ASSERT_NOW(a_done_busy, conv_done, busy_r)
  `IFMT_ASSERT_NOW(a_fin_last, emit_fin, out_valid && out_last)
  `IFMT_ASSERT_NEXT(a_fin_free, emit_fin, in_ready)

endmodule

/* test/int_field_formatter_checker.sv */
// checker for the integer field formatter: watches both channels, builds the expected
// characters of every accepted field and compares each result beat in order
// depends on ifmt_pkg
`timescale 1ns / 1ps

module int_field_formatter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_use_hex,
  input  logic [5:0]  in_width,
  input  logic [5:0]  in_precision,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_ch,
  input  logic        out_last,
  output int          mismatches,
  output int          pending
);

  localparam logic [7:0] CH_HEX_A = 8'h61;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  char_beat_t field_chars[$];
  char_beat_t head;

  // expected characters of one field, sign and magnitude, leftmost first
  function automatic void queue_field(input logic [31:0] value, input logic use_hex,
                                      input logic [5:0] width, input logic [5:0] prec);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  digs[24];
    logic [7:0]  line[$];
    char_beat_t  beat;
    int          nd;
    int          body;
    int          i;
    neg = value[31];
    mag = neg ? (~value + 32'd1) : value;
    nd = 0;
    do begin
      digs[nd] = use_hex ? mag[3:0] : 4'(mag % 32'd10);
      mag = use_hex ? (mag >> 4) : (mag / 32'd10);
      nd++;
    end while (mag != 0);
    body = ((int'(prec) > nd) ? int'(prec) : nd) + (neg ? 1 : 0);
    for (i = body; i < int'(width); i++) line.push_back(ifmt_pkg::CH_SPACE);
    if (neg) line.push_back(ifmt_pkg::CH_MINUS);
    for (i = nd; i < int'(prec); i++) line.push_back(ifmt_pkg::CH_ZERO);
    for (i = nd; i > 0; i--) begin
      if (digs[i-1] < 4'd10) line.push_back(ifmt_pkg::CH_ZERO + 8'(digs[i-1]));
      else line.push_back(CH_HEX_A + 8'(digs[i-1] - 4'd10));
    end
    foreach (line[k]) begin
      beat.ch   = line[k];
      beat.last = (k == line.size() - 1);
      field_chars.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) queue_field(in_value, in_use_hex, in_width, in_precision);
      if (out_valid && out_ready) begin
        if (field_chars.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual ch %h last %b",
                   $time, out_ch, out_last);
          mismatches++;
        end else begin
          head = field_chars.pop_front();
          if (out_ch !== head.ch) begin
            $display("%0t: ch expected %h actual %h", $time, head.ch, out_ch);
            mismatches++;
          end
          if (out_last !== head.last) begin
            $display("%0t: last expected %b actual %b", $time, head.last, out_last);
            mismatches++;
          end
        end
      end
    end
    pending = field_chars.size();
  end

endmodule

/* test/tb_int_field_formatter_core.sv */
// testbench top for int_field_formatter_core: directed and random fields with random
// stalls on both sides, results checked by int_field_formatter_checker
// depends on ifmt_pkg, int_field_formatter_core and int_field_formatter_checker
`timescale 1ns / 1ps

module tb_int_field_formatter_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_value;
  logic               in_use_hex;
  logic [5:0]         in_width;
  logic [5:0]         in_precision;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_ch;
  logic               out_last;

  int mismatches;
  int pending;
  int cycles;
  bit idling;
  bit hold_off_req;
  bit hold_taken;

  int_field_formatter_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_use_hex   (in_use_hex),
    .in_width     (in_width),
    .in_precision (in_precision),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ch       (out_ch),
    .out_last     (out_last)
  );

  int_field_formatter_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_use_hex   (in_use_hex),
    .in_width     (in_width),
    .in_precision (in_precision),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ch       (out_ch),
    .out_last     (out_last),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stall bursts, and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic offer_field(input logic [31:0] v, input logic hex,
                             input logic [5:0] w, input logic [5:0] p);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value     = v;
    in_use_hex   = hex;
    in_width     = w;
    in_precision = p;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 20);
      3: v = -$urandom_range(1, 300);
      4: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0;
          3: v = 32'hffff_ffff;
          default: v = 32'h1;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [5:0] pick_len();
    return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 14));
  endfunction

  task automatic offer_random(input int count);
    repeat (count) offer_field(pick_value(), 1'($urandom_range(0, 1)), pick_len(), pick_len());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    in_use_hex   = 1'b0;
    in_width     = '0;
    in_precision = '0;
    idling       = 1'b0;
    hold_off_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    offer_field(32'd0, 1'b0, 6'd0, 6'd0);
    offer_field(32'd0, 1'b1, 6'd0, 6'd0);
    offer_field(32'd0, 1'b0, 6'd0, 6'd5);
    offer_field(32'h8000_0000, 1'b0, 6'd0, 6'd0);
    offer_field(32'h8000_0000, 1'b1, 6'd0, 6'd0);
    offer_field(32'h7fff_ffff, 1'b0, 6'd0, 6'd0);
    offer_field(32'h7fff_ffff, 1'b1, 6'd0, 6'd0);
    offer_field(32'hffff_ffff, 1'b0, 6'd0, 6'd0);
    offer_field(32'hffff_ffff, 1'b1, 6'd0, 6'd0);
    offer_field(32'd1, 1'b0, 6'd63, 6'd0);
    offer_field(-32'sd42, 1'b0, 6'd63, 6'd63);
    offer_field(32'd123456, 1'b0, 6'd0, 6'd3);
    offer_field(32'd123456, 1'b0, 6'd4, 6'd0);
    offer_field(32'd255, 1'b1, 6'd8, 6'd4);
    offer_field(-32'sd255, 1'b1, 6'd8, 6'd4);
    offer_field(32'hdead_beef, 1'b1, 6'd12, 6'd10);
    offer_field(32'd9, 1'b0, 6'd3, 6'd3);
    offer_field(32'd10, 1'b1, 6'd1, 6'd1);
    offer_field(-32'sd7, 1'b0, 6'd63, 6'd1);
    offer_field(32'd1000000000, 1'b0, 6'd20, 6'd12);
    offer_field(32'd63, 1'b0, 6'd63, 6'd63);
    offer_field(-32'sd2147483647, 1'b0, 6'd15, 6'd15);

    idling = 1'b1;
    offer_random(100);

    // long receiver hold-off while fields keep coming
    hold_off_req = 1'b1;
    offer_random(8);
    offer_random(60);

    // sender pause until the block has drained
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    offer_random(110);

    idling = 1'b0;
    offer_random(80);
    in_valid = 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
